/* rtl/mpm_pkg.sv */
package mpm_pkg;

	// Channel store size and the widths that follow from it.
	localparam int MAX_CHANNELS = 8;
	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NUM_W = $clog2(MAX_CHANNELS + 1);

	// Field widths of the request, the result and the register port.
	localparam int OP_W = 2;
	localparam int CH_W = 3;
	localparam int SAMPLE_W = 16;
	localparam int DB_W = 15;
	localparam int AGE_W = 16;
	localparam int DECAY_W = 14;
	localparam int ACTIVE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Log converter: fraction bits of log2, one squaring per cycle.
	localparam int LOG_FRAC_BITS = 16;
	localparam int SQ_W = $clog2(LOG_FRAC_BITS);
	localparam int EXP_W = 4;
	localparam int PROD_W = 48;

	// 2000 * log10(2) / 2^16 scaled by 2^32, and the rounding bias.
	localparam logic signed [26:0] LOG_SCALE = 27'sd39456604;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = 48'sd2147483648;

	// Levels in 0.01 dB.
	localparam logic signed [DB_W-1:0] DB_SILENT = -15'sd10000;
	localparam logic signed [DB_W-1:0] TP_CORR = 15'sd30;

	// Register reset values.
	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd2;
	localparam logic [DECAY_W-1:0] DECAY_RST = 14'd20;
	localparam logic signed [DB_W-1:0] FLOOR_RST = -15'sd6000;
	localparam logic [AGE_W-1:0] HOLD_RST = 16'd90;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_CHANNELS = 3'd0,
		CFG_TRUE_PEAK_MODE  = 3'd1,
		CFG_DECAY_PER_TICK  = 3'd2,
		CFG_FLOOR_DB        = 3'd3,
		CFG_HOLD_TICKS      = 3'd4,
		CFG_HOLD_FOREVER    = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_NORM,
		ST_SQUARE,
		ST_SCALE,
		ST_ROUND,
		ST_APPLY,
		ST_TICK,
		ST_CLEAR,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0]    active_channels;
		logic                   true_peak_mode;
		logic [DECAY_W-1:0]     decay_per_tick;
		logic signed [DB_W-1:0] floor_db;
		logic [AGE_W-1:0]       hold_ticks;
		logic                   hold_forever;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic norm;
		logic square;
		logic scale;
		logic round;
		logic apply;
		logic tick_step;
		logic clear;
		logic report;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_e_t op;
		logic  ch_active;
		logic  tick_last;
		logic  out_free;
	} status_t;

endpackage

/* rtl/mpm_in_if.sv */
interface mpm_in_if;
	import mpm_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [CH_W-1:0]     channel;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output op, output channel, output sample, input ready);
	modport sink (input valid, input op, input channel, input sample, output ready);

endinterface

/* rtl/mpm_out_if.sv */
interface mpm_out_if;
	import mpm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CH_W-1:0]        report_channel;
	logic signed [DB_W-1:0] level_db;
	logic signed [DB_W-1:0] peak_db;
	logic                   clip;
	logic                   accepted;

	modport source (
		output valid, output report_channel, output level_db, output peak_db,
		output clip, output accepted, input ready
	);
	modport sink (
		input valid, input report_channel, input level_db, input peak_db,
		input clip, input accepted, output ready
	);

endinterface

/* rtl/mpm_cfg_if.sv */
interface mpm_cfg_if;
	import mpm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

/* rtl/mpm_cfg_regs.sv */
module mpm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	output logic                           wr_ready,
	input  logic [mpm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mpm_pkg::CFG_DATA_W-1:0] wr_data,
	output mpm_pkg::cfg_t                  cfg
);
	import mpm_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken; an index beyond the register list is dropped.
	assign wr_ready = 1'b1;
	assign cfg = cfg_q;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_channels <= ACTIVE_RST;
			cfg_q.true_peak_mode <= 1'b0;
			cfg_q.decay_per_tick <= DECAY_RST;
			cfg_q.floor_db <= FLOOR_RST;
			cfg_q.hold_ticks <= HOLD_RST;
			cfg_q.hold_forever <= 1'b0;
		end else if (wr_valid) begin
			case (wr_index)
				CFG_ACTIVE_CHANNELS: cfg_q.active_channels <= wr_data[ACTIVE_W-1:0];
				CFG_TRUE_PEAK_MODE:  cfg_q.true_peak_mode <= wr_data[0];
				CFG_DECAY_PER_TICK:  cfg_q.decay_per_tick <= wr_data[DECAY_W-1:0];
				CFG_FLOOR_DB:        cfg_q.floor_db <= $signed(wr_data[DB_W-1:0]);
				CFG_HOLD_TICKS:      cfg_q.hold_ticks <= wr_data[AGE_W-1:0];
				CFG_HOLD_FOREVER:    cfg_q.hold_forever <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/mpm_ctrl.sv */
module mpm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mpm_pkg::status_t status,
	output mpm_pkg::cmd_t    cmd
);
	import mpm_pkg::*;

	state_t          state_q;
	state_t          state_next;
	logic [SQ_W-1:0] sq_cnt_q;
	logic            sq_last;

	assign sq_last = (sq_cnt_q == SQ_W'(LOG_FRAC_BITS - 1));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Squaring step counter of the log converter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.norm) begin
			sq_cnt_q <= '0;
		end else if (cmd.square) begin
			sq_cnt_q <= sq_cnt_q + SQ_W'(1);
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.op)
					OP_SAMPLE: state_next = status.ch_active ? ST_NORM : ST_REPORT;
					OP_TICK:   state_next = ST_TICK;
					OP_CLEAR:  state_next = ST_CLEAR;
					default:   state_next = ST_REPORT;
				endcase
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_next = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				if (sq_last) begin
					state_next = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_next = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_next = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_next = ST_REPORT;
			end
			ST_TICK: begin
				cmd.tick_step = 1'b1;
				if (status.tick_last) begin
					state_next = ST_REPORT;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_next = ST_REPORT;
			end
			ST_REPORT: begin
				if (status.out_free) begin
					cmd.report = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

endmodule

/* rtl/mpm_dp.sv */
module mpm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpm_pkg::cmd_t                       cmd,
	output mpm_pkg::status_t                    status,
	input  mpm_pkg::cfg_t                       cfg,
	input  logic [mpm_pkg::OP_W-1:0]            op,
	input  logic [mpm_pkg::CH_W-1:0]            channel,
	input  logic [mpm_pkg::SAMPLE_W-1:0]        sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mpm_pkg::CH_W-1:0]            report_channel,
	output logic signed [mpm_pkg::DB_W-1:0]     level_db,
	output logic signed [mpm_pkg::DB_W-1:0]     peak_db,
	output logic                                clip,
	output logic                                accepted
);
	import mpm_pkg::*;

	// Request registers.
	logic [OP_W-1:0]     op_q;
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]    idx_q;

	// Log converter registers.
	logic [SAMPLE_W-1:0]      m_q;
	logic [EXP_W-1:0]         e_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DB_W-1:0]   db_q;

	// Channel stores.
	logic signed [DB_W-1:0] level_q [MAX_CHANNELS];
	logic signed [DB_W-1:0] peak_q [MAX_CHANNELS];
	logic [AGE_W-1:0]       age_q [MAX_CHANNELS];
	logic                   clip_q [MAX_CHANNELS];

	// Result register.
	logic                   out_valid_q;
	logic [CH_W-1:0]        out_ch_q;
	logic signed [DB_W-1:0] out_level_q;
	logic signed [DB_W-1:0] out_peak_q;
	logic                   out_clip_q;
	logic                   out_acc_q;

	logic [IDX_W-1:0]         rd_idx;
	logic signed [DB_W-1:0]   rd_level;
	logic signed [DB_W-1:0]   rd_peak;
	logic [AGE_W-1:0]         rd_age;
	logic                     rd_clip;
	logic [AGE_W-1:0]         age_inc;
	logic [EXP_W-1:0]         lead_e;
	logic [SAMPLE_W-1:0]      norm_m;
	logic [2*SAMPLE_W-1:0]    sq;
	logic [SAMPLE_W:0]        sq_hi;
	logic [4:0]               e_off;
	logic signed [20:0]       lg;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd;
	logic signed [DB_W-1:0]   db_calc;
	logic [NUM_W-1:0]         used_n;
	logic                     ch_active;
	logic                     ch_in_store;
	logic                     out_free;
	logic                     acc_flag;

	// Decay toward the floor, never below it.
	function automatic logic signed [DB_W-1:0] fall_to_floor(
		input logic signed [DB_W-1:0] v,
		input logic [DECAY_W-1:0]     dec,
		input logic signed [DB_W-1:0] fl
	);
		logic signed [DB_W+1:0] r;
		r = (DB_W+2)'(v) - $signed({3'b000, dec});
		if (r < (DB_W+2)'(fl)) begin
			return fl;
		end
		return r[DB_W-1:0];
	endfunction

	// Channel count in use, clamped to the store size.
	always_comb begin
		if (cfg.active_channels == '0) begin
			used_n = NUM_W'(1);
		end else if ({1'b0, cfg.active_channels} > 5'(MAX_CHANNELS)) begin
			used_n = NUM_W'(MAX_CHANNELS);
		end else begin
			used_n = NUM_W'(cfg.active_channels);
		end
	end

	assign ch_active = 5'(ch_q) < 5'(used_n);
	assign ch_in_store = 5'(ch_q) < 5'(MAX_CHANNELS);
	assign out_free = !out_valid_q || out_ready;

	assign status.op = op_e_t'(op_q);
	assign status.ch_active = ch_active;
	assign status.tick_last = (5'(idx_q) == 5'(used_n) - 5'd1);
	assign status.out_free = out_free;

	// Single store read port: the tick walker or the requested channel.
	assign rd_idx = cmd.tick_step ? idx_q : IDX_W'(ch_q);
	assign rd_level = level_q[rd_idx];
	assign rd_peak = peak_q[rd_idx];
	assign rd_age = age_q[rd_idx];
	assign rd_clip = clip_q[rd_idx];
	assign age_inc = (rd_age != '1) ? rd_age + AGE_W'(1) : rd_age;

	// Leading one and normalization of the sample.
	always_comb begin
		lead_e = '0;
		for (int i = 0; i < SAMPLE_W; i++) begin
			if (sample_q[i]) begin
				lead_e = EXP_W'(i);
			end
		end
		norm_m = sample_q << (EXP_W'(SAMPLE_W - 1) - lead_e);
	end

	// One squaring step yields one fraction bit of log2.
	assign sq = m_q * m_q;
	assign sq_hi = sq[2*SAMPLE_W-1:SAMPLE_W-1];

	// Log2 in Q16 times the dB scale, then rounding half up.
	assign e_off = {1'b0, e_q} - 5'd15;
	assign lg = $signed({e_off, frac_q});
	assign prod = lg * LOG_SCALE;
	assign rnd = prod_q + ROUND_BIAS;

	// Silence converts to -100 dB; the true-peak correction applies to it as well.
	always_comb begin
		if (sample_q == '0) begin
			db_calc = DB_SILENT + (cfg.true_peak_mode ? TP_CORR : '0);
		end else begin
			db_calc = $signed(rnd[DB_W+31:32]) + (cfg.true_peak_mode ? TP_CORR : '0);
		end
	end

	// Request capture and tick walker index.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			ch_q <= channel;
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.tick_step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Log converter.
	always_ff @(posedge clk) begin
		if (cmd.norm) begin
			m_q <= norm_m;
			e_q <= lead_e;
			frac_q <= '0;
		end else if (cmd.square) begin
			if (sq_hi[SAMPLE_W]) begin
				m_q <= sq_hi[SAMPLE_W:1];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
			end else begin
				m_q <= sq_hi[SAMPLE_W-1:0];
				frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
			end
		end
		if (cmd.scale) begin
			prod_q <= prod;
		end
		if (cmd.round) begin
			db_q <= db_calc;
		end
	end

	// Channel stores: sample update, tick decay and clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				level_q[i] <= DB_SILENT;
				peak_q[i] <= DB_SILENT;
				age_q[i] <= '0;
				clip_q[i] <= 1'b0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				peak_q[i] <= DB_SILENT;
				age_q[i] <= '0;
				clip_q[i] <= 1'b0;
			end
		end else if (cmd.apply) begin
			if (db_q > rd_level) begin
				level_q[rd_idx] <= db_q;
			end
			if (db_q >= rd_peak) begin
				peak_q[rd_idx] <= db_q;
				age_q[rd_idx] <= '0;
			end
			if (sample_q[SAMPLE_W-1]) begin
				clip_q[rd_idx] <= 1'b1;
			end
		end else if (cmd.tick_step) begin
			level_q[rd_idx] <= fall_to_floor(rd_level, cfg.decay_per_tick, cfg.floor_db);
			if (!cfg.hold_forever) begin
				age_q[rd_idx] <= age_inc;
				if (age_inc > cfg.hold_ticks) begin
					peak_q[rd_idx] <= fall_to_floor(rd_peak, cfg.decay_per_tick, cfg.floor_db);
				end
			end
		end
	end

	// A sample on an inactive channel and an unknown op are not accepted.
	always_comb begin
		if (op_q == OP_SAMPLE) begin
			acc_flag = ch_active;
		end else begin
			acc_flag = (op_q == OP_TICK) || (op_q == OP_CLEAR);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			out_ch_q <= ch_q;
			out_level_q <= ch_in_store ? rd_level : DB_SILENT;
			out_peak_q <= ch_in_store ? rd_peak : DB_SILENT;
			out_clip_q <= ch_in_store ? rd_clip : 1'b0;
			out_acc_q <= acc_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign report_channel = out_ch_q;
	assign level_db = out_level_q;
	assign peak_db = out_peak_q;
	assign clip = out_clip_q;
	assign accepted = out_acc_q;

endmodule

/* rtl/multichannel_peak_meter.sv */
// Request to result: a sample on an active channel passes dispatch, normalization, the
// squaring log2 unit, scaling, rounding and the store update; a tick walks the active
// channels one channel per cycle through the shared decay unit; a clear passes the clear state.
// An ignored request goes straight to the report. Requests are taken one at a time; the next
// request is taken while a finished result waits in the output register.
// Reset (arst_n low): levels and peaks -100 dB, ages and clips cleared, registers to defaults.
module multichannel_peak_meter (
	input logic        clk,
	input logic        arst_n,
	mpm_in_if.sink     item,
	mpm_out_if.source  result,
	mpm_cfg_if.sink    cfg
);
	import mpm_pkg::*;

	cfg_t    cfg_regs;
	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign item.ready = in_ready;

	mpm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	mpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mpm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg            (cfg_regs),
		.op             (item.op),
		.channel        (item.channel),
		.sample         (item.sample),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.report_channel (result.report_channel),
		.level_db       (result.level_db),
		.peak_db        (result.peak_db),
		.clip           (result.clip),
		.accepted       (result.accepted)
	);

	// One request at a time: no request is taken right after another.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("request taken while the previous one is in flight");

	// A result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> status.out_free)
		else $error("result register overwritten");

	// The controller issues at most one command per cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.norm, cmd.square, cmd.scale, cmd.round, cmd.apply,
			cmd.tick_step, cmd.clear, cmd.report}))
		else $error("conflicting datapath commands");

	// Each report is followed by readiness for the next request.
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |=> item.ready)
		else $error("controller not idle after a report");

endmodule
